// ===== sv/slpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool package
// Item modes, result status codes, CSR indices and field widths for the pool.
// ----------------------------------------------------------------------------
package slpr_pkg;

   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 12;
   localparam int FAMILY_W = 4;
   localparam int FRAME_W  = 32;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int EVENT_W  = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT    = 3'd0,
      MODE_ACQUIRE = 3'd1,
      MODE_RELEASE = 3'd2,
      MODE_MARK    = 3'd3,
      MODE_DIRTY   = 3'd4,
      MODE_QUERY   = 3'd5,
      MODE_FRAME   = 3'd6,
      MODE_RESET   = 3'd7
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_IGNORED   = 2'd2,
      ST_SPARE     = 2'd3
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ALLOW_GROWTH = 2'd0,
      CSR_MAX_SLOTS    = 2'd1,
      CSR_INIT_SLOTS   = 2'd2,
      CSR_IDLE_LIMIT   = 2'd3
   } csr_type;

endpackage
`default_nettype wire

// ===== sv/slot_pool_with_age_reclaim_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot pool with age reclaim
// FIFO free-list slot allocator with growth, release, recorded marks,
// frame-based reclaim of idle slots and a full reset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  req_    | in        | req_valid / req_ready  | mode, slot index, family, frame
//  rsp_    | out       | rsp_valid / rsp_ready  | status, grant, query, statistics
//  csr_    | in        | csr_wr_en              | register index and data
//
//  Each word runs through the execute and done states; an acquire also
//  pops and takes a slot, after a fill when it grows; init and reset-all
//  fill the free list; a frame scans the live slots one at a time, as the
//  scan reads the last-frame RAM through its single read port.
//  After reset the free list is filled with up to 64 slots, one per cycle,
//  so req_ready stays low until the fill ends. One word is in flight at a
//  time; req_ready also needs the previous result taken or being taken.
//  The queue family is never visible on a result and is not stored.
//  Busy and recorded flags live in two small RAMs; the slot flags for a
//  word are read at its accepting edge, so they are ready when it executes.
//  Every fill clears the flags of the slots that it pushes.
// ----------------------------------------------------------------------------
module slot_pool_with_age_reclaim_core #(
   parameter int POOL_SLOTS = 256,
   parameter int GROW_CHUNK = 16,
   parameter int FRAME_BITS = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [slpr_pkg::MODE_W-1:0]      req_mode,
   input  logic [slpr_pkg::INDEX_W-1:0]     req_slot_index,
   input  logic [slpr_pkg::FAMILY_W-1:0]    req_queue_family,
   input  logic [slpr_pkg::FRAME_W-1:0]     req_frame_number,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [slpr_pkg::STATUS_W-1:0]    rsp_status,
   output logic [slpr_pkg::GRANT_W-1:0]     rsp_granted_slot,
   output logic                             rsp_is_recorded,
   output logic [slpr_pkg::COUNT_W-1:0]     rsp_slot_handle,
   output logic [slpr_pkg::COUNT_W-1:0]     rsp_live_slots,
   output logic [slpr_pkg::COUNT_W-1:0]     rsp_free_slots,
   output logic [slpr_pkg::COUNT_W-1:0]     rsp_recorded_slots,
   output logic [slpr_pkg::EVENT_W-1:0]     rsp_growth_count,
   output logic [slpr_pkg::EVENT_W-1:0]     rsp_reclaim_count,

   input  logic                             csr_wr_en,
   input  logic [slpr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [slpr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slpr_pkg::*;

   localparam int PTR_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
   localparam int WIDE_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int BOOT_N = (POOL_SLOTS < 64) ? POOL_SLOTS : 64;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_FILL = 8'b0000_0100,
      S_POP  = 8'b0000_1000,
      S_TAKE = 8'b0001_0000,
      S_SCAN = 8'b0010_0000,
      S_AGE  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   // sequencer and item
   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                   boot_ff, boot_in;

   // configuration
   logic                   allow_ff;
   logic [COUNT_W-1:0]     max_ff;
   logic [COUNT_W-1:0]     init_ff;
   logic [FRAME_W-1:0]     limit_ff;

   // pool state
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]       pool_ff, pool_in;
   logic [CNT_W-1:0]       rtot_ff, rtot_in;
   logic [FRAME_BITS-1:0]  cur_ff, cur_in;
   logic [EVENT_W-1:0]     grow_ev_ff, grow_ev_in;
   logic [EVENT_W-1:0]     recl_ev_ff, recl_ev_in;

   // fill and scan counters
   logic [CNT_W-1:0]       left_ff, left_in;
   logic [CNT_W-1:0]       fval_ff, fval_in;
   logic                   fgrow_ff, fgrow_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;

   // result word
   logic                   rv_ff, rv_in;
   logic [STATUS_W-1:0]    rst_ff, rst_in;
   logic [GRANT_W-1:0]     rgr_ff, rgr_in;
   logic                   rrec_ff, rrec_in;
   logic [COUNT_W-1:0]     rhd_ff, rhd_in;
   logic [COUNT_W-1:0]     rlive_ff, rlive_in;
   logic [COUNT_W-1:0]     rfree_ff, rfree_in;
   logic [COUNT_W-1:0]     rrecs_ff, rrecs_in;
   logic [EVENT_W-1:0]     rgrow_ff, rgrow_in;
   logic [EVENT_W-1:0]     rrecl_ff, rrecl_in;

   // memories
   logic                   fl_we, fl_re;
   logic [PTR_W-1:0]       fl_wa;
   logic [PTR_W-1:0]       fl_rd;
   logic                   lf_we, lf_re;
   logic [PTR_W-1:0]       lf_wa, lf_ra;
   logic [FRAME_BITS-1:0]  lf_rd;
   logic                   aged;
   logic                   fg_re;
   logic [PTR_W-1:0]       fg_ra;
   logic                   bw_we, bw_wd, busy_rd;
   logic [PTR_W-1:0]       bw_wa;
   logic                   rw_we, rw_wd, recd_rd;
   logic [PTR_W-1:0]       rw_wa;

   // helper terms
   logic                   accept;
   logic                   in_range;
   logic [PTR_W-1:0]       iptr;
   logic [PTR_W-1:0]       sptr;
   logic [WIDE_W-1:0]      cap_w, room_w, grow_n_w, init_w;
   logic                   push_en;
   logic [PTR_W-1:0]       push_val;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(POOL_SLOTS - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign iptr     = idx_ff[PTR_W-1:0];
   assign sptr     = scan_ff[PTR_W-1:0];
   assign in_range = WIDE_W'(idx_ff) < WIDE_W'(pool_ff);

   // growth size: clamp max_slots to the pool, then to one chunk
   always_comb begin
      cap_w = (WIDE_W'(max_ff) > WIDE_W'(POOL_SLOTS)) ? WIDE_W'(POOL_SLOTS)
                                                       : WIDE_W'(max_ff);
      room_w   = cap_w - WIDE_W'(pool_ff);
      grow_n_w = (room_w < WIDE_W'(GROW_CHUNK)) ? room_w : WIDE_W'(GROW_CHUNK);
      init_w   = (WIDE_W'(init_ff) > WIDE_W'(POOL_SLOTS)) ? WIDE_W'(POOL_SLOTS)
                                                           : WIDE_W'(init_ff);
   end

   slpr_ram #(
      .WIDTH (PTR_W),
      .DEPTH (POOL_SLOTS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (fl_we),
      .wr_addr (fl_wa),
      .wr_data (push_val),
      .rd_en   (fl_re),
      .rd_addr (head_ff),
      .rd_data (fl_rd)
   );

   slpr_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (POOL_SLOTS)
   ) u_last_frame (
      .clock   (clock),
      .wr_en   (lf_we),
      .wr_addr (lf_wa),
      .wr_data (cur_ff),
      .rd_en   (lf_re),
      .rd_addr (lf_ra),
      .rd_data (lf_rd)
   );

   slpr_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SLOTS)
   ) u_busy (
      .clock   (clock),
      .wr_en   (bw_we),
      .wr_addr (bw_wa),
      .wr_data (bw_wd),
      .rd_en   (fg_re),
      .rd_addr (fg_ra),
      .rd_data (busy_rd)
   );

   slpr_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SLOTS)
   ) u_recorded (
      .clock   (clock),
      .wr_en   (rw_we),
      .wr_addr (rw_wa),
      .wr_data (rw_wd),
      .rd_en   (fg_re),
      .rd_addr (fg_ra),
      .rd_data (recd_rd)
   );

   slpr_age_cmp #(
      .FRAME_BITS (FRAME_BITS)
   ) u_age_cmp (
      .cur_frame  (cur_ff),
      .last_frame (lf_rd),
      .idle_limit (limit_ff),
      .aged       (aged)
   );

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      idx_in     = idx_ff;
      frame_in   = frame_ff;
      boot_in    = boot_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fcnt_in    = fcnt_ff;
      pool_in    = pool_ff;
      rtot_in    = rtot_ff;
      cur_in     = cur_ff;
      grow_ev_in = grow_ev_ff;
      recl_ev_in = recl_ev_ff;
      left_in    = left_ff;
      fval_in    = fval_ff;
      fgrow_in   = fgrow_ff;
      scan_in    = scan_ff;
      rv_in      = rv_ff;
      rst_in     = rst_ff;
      rgr_in     = rgr_ff;
      rrec_in    = rrec_ff;
      rhd_in     = rhd_ff;
      rlive_in   = rlive_ff;
      rfree_in   = rfree_ff;
      rrecs_in   = rrecs_ff;
      rgrow_in   = rgrow_ff;
      rrecl_in   = rrecl_ff;
      push_en    = 1'b0;
      push_val   = '0;
      fl_re      = 1'b0;
      lf_we      = 1'b0;
      lf_wa      = fl_rd;
      lf_re      = 1'b0;
      lf_ra      = sptr;
      fg_re      = 1'b0;
      fg_ra      = sptr;
      bw_we      = 1'b0;
      bw_wa      = iptr;
      bw_wd      = 1'b0;
      rw_we      = 1'b0;
      rw_wa      = iptr;
      rw_wd      = 1'b0;

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = mode_type'(req_mode);
               idx_in   = req_slot_index;
               frame_in = FRAME_BITS'(req_frame_number);
               // fetch the addressed slot flags for the execute cycle
               fg_re    = 1'b1;
               fg_ra    = req_slot_index[PTR_W-1:0];
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            rst_in   = ST_OK;
            rgr_in   = '0;
            rrec_in  = 1'b0;
            rhd_in   = '0;
            state_in = S_DONE;
            unique case (mode_ff)
               MODE_INIT: begin
                  head_in    = '0;
                  tail_in    = '0;
                  fcnt_in    = '0;
                  pool_in    = '0;
                  rtot_in    = '0;
                  cur_in     = '0;
                  grow_ev_in = '0;
                  recl_ev_in = '0;
                  left_in    = CNT_W'(init_w);
                  fgrow_in   = 1'b1;
                  state_in   = S_FILL;
               end
               MODE_ACQUIRE: begin
                  if (fcnt_ff != '0) begin
                     state_in = S_POP;
                  end else if (!allow_ff || (WIDE_W'(pool_ff) >= cap_w)) begin
                     rst_in = ST_EXHAUSTED;
                  end else begin
                     grow_ev_in = grow_ev_ff + 1'b1;
                     left_in    = CNT_W'(grow_n_w);
                     fgrow_in   = 1'b1;
                     state_in   = S_FILL;
                  end
               end
               MODE_RELEASE: begin
                  if (in_range && busy_rd) begin
                     bw_we = 1'b1;
                     rw_we = 1'b1;
                     if (recd_rd) begin
                        rtot_in = rtot_ff - 1'b1;
                     end
                     push_en  = 1'b1;
                     push_val = iptr;
                  end else begin
                     rst_in = ST_IGNORED;
                  end
               end
               MODE_MARK, MODE_DIRTY: begin
                  if (in_range) begin
                     rw_we = 1'b1;
                     if (mode_ff == MODE_MARK) begin
                        rw_wd = 1'b1;
                        if (!recd_rd) begin
                           rtot_in = rtot_ff + 1'b1;
                        end
                     end else begin
                        if (recd_rd) begin
                           rtot_in = rtot_ff - 1'b1;
                        end
                     end
                  end else begin
                     rst_in = ST_IGNORED;
                  end
               end
               MODE_QUERY: begin
                  if (in_range) begin
                     rrec_in = recd_rd;
                     rhd_in  = COUNT_W'(WIDE_W'(idx_ff) + 1'b1);
                  end else begin
                     rst_in = ST_IGNORED;
                  end
               end
               MODE_FRAME: begin
                  cur_in  = frame_ff;
                  scan_in = '0;
                  if (pool_ff != '0) begin
                     state_in = S_SCAN;
                  end
               end
               MODE_RESET: begin
                  // recorded flags above the live size are never read
                  head_in  = '0;
                  tail_in  = '0;
                  fcnt_in  = '0;
                  rtot_in  = '0;
                  fval_in  = '0;
                  left_in  = pool_ff;
                  fgrow_in = 1'b0;
                  state_in = S_FILL;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // push one slot a cycle: fresh slots on growth, else 0 upwards;
         // clear the flags of each pushed slot
         S_FILL: begin
            if (left_ff == '0) begin
               boot_in = 1'b0;
               if (boot_ff) begin
                  state_in = S_IDLE;
               end else if (mode_ff == MODE_ACQUIRE) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               push_en = 1'b1;
               left_in = left_ff - 1'b1;
               if (fgrow_ff) begin
                  push_val = pool_ff[PTR_W-1:0];
                  pool_in  = pool_ff + 1'b1;
               end else begin
                  push_val = fval_ff[PTR_W-1:0];
                  fval_in  = fval_ff + 1'b1;
               end
               bw_we = 1'b1;
               bw_wa = push_val;
               rw_we = 1'b1;
               rw_wa = push_val;
            end
         end

         S_POP: begin
            fl_re    = 1'b1;
            state_in = S_TAKE;
         end

         S_TAKE: begin
            bw_we    = 1'b1;
            bw_wa    = fl_rd;
            bw_wd    = 1'b1;
            lf_we    = 1'b1;
            lf_wa    = fl_rd;
            head_in  = ptr_inc(head_ff);
            fcnt_in  = fcnt_ff - 1'b1;
            rgr_in   = GRANT_W'(fl_rd);
            state_in = S_DONE;
         end

         S_SCAN: begin
            lf_re    = 1'b1;
            fg_re    = 1'b1;
            state_in = S_AGE;
         end

         S_AGE: begin
            if (busy_rd && !recd_rd && aged) begin
               bw_we      = 1'b1;
               bw_wa      = sptr;
               push_en    = 1'b1;
               push_val   = sptr;
               recl_ev_in = recl_ev_ff + 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = ((scan_ff + 1'b1) < pool_ff) ? S_SCAN : S_DONE;
         end

         S_DONE: begin
            rv_in    = 1'b1;
            rlive_in = COUNT_W'(pool_ff);
            rfree_in = COUNT_W'(fcnt_ff);
            rrecs_in = COUNT_W'(rtot_ff);
            rgrow_in = grow_ev_ff;
            rrecl_in = recl_ev_ff;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // free-list push: drop it when the list is already full
      fl_we = 1'b0;
      fl_wa = tail_ff;
      if (push_en && (fcnt_in < CNT_W'(POOL_SLOTS))) begin
         fl_we   = 1'b1;
         tail_in = ptr_inc(tail_ff);
         fcnt_in = fcnt_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_FILL;
         boot_ff    <= 1'b1;
         mode_ff    <= MODE_INIT;
         head_ff    <= '0;
         tail_ff    <= '0;
         fcnt_ff    <= '0;
         pool_ff    <= '0;
         rtot_ff    <= '0;
         cur_ff     <= '0;
         grow_ev_ff <= '0;
         recl_ev_ff <= '0;
         left_ff    <= CNT_W'(BOOT_N);
         fval_ff    <= '0;
         fgrow_ff   <= 1'b1;
         scan_ff    <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         boot_ff    <= boot_in;
         mode_ff    <= mode_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fcnt_ff    <= fcnt_in;
         pool_ff    <= pool_in;
         rtot_ff    <= rtot_in;
         cur_ff     <= cur_in;
         grow_ev_ff <= grow_ev_in;
         recl_ev_ff <= recl_ev_in;
         left_ff    <= left_in;
         fval_ff    <= fval_in;
         fgrow_ff   <= fgrow_in;
         scan_ff    <= scan_in;
         rv_ff      <= rv_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      frame_ff <= frame_in;
      rst_ff   <= rst_in;
      rgr_ff   <= rgr_in;
      rrec_ff  <= rrec_in;
      rhd_ff   <= rhd_in;
      rlive_ff <= rlive_in;
      rfree_ff <= rfree_in;
      rrecs_ff <= rrecs_in;
      rgrow_ff <= rgrow_in;
      rrecl_ff <= rrecl_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b1;
         max_ff   <= COUNT_W'(256);
         init_ff  <= COUNT_W'(64);
         limit_ff <= FRAME_W'(3);
      end else if (csr_wr_en) begin
         unique case (csr_type'(csr_addr))
            CSR_ALLOW_GROWTH: allow_ff <= csr_wdata[0];
            CSR_MAX_SLOTS:    max_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_INIT_SLOTS:   init_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_IDLE_LIMIT:   limit_ff <= csr_wdata[FRAME_W-1:0];
            default:          allow_ff <= allow_ff;
         endcase
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_granted_slot   = rgr_ff;
   assign rsp_is_recorded    = rrec_ff;
   assign rsp_slot_handle    = rhd_ff;
   assign rsp_live_slots     = rlive_ff;
   assign rsp_free_slots     = rfree_ff;
   assign rsp_recorded_slots = rrecs_ff;
   assign rsp_growth_count   = rgrow_ff;
   assign rsp_reclaim_count  = rrecl_ff;

   // the free list never holds more entries than live slots
   a_free_le_live: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= pool_ff)
      else $error("free count exceeds live size");

   a_recd_le_live: assert property (@(posedge clock) disable iff (reset)
      rtot_ff <= pool_ff)
      else $error("recorded count exceeds live size");

   a_live_le_pool: assert property (@(posedge clock) disable iff (reset)
      pool_ff <= CNT_W'(POOL_SLOTS))
      else $error("live size beyond pool");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC) && !rv_ff)
      else $error("accepted word did not start execution");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (fcnt_ff != '0))
      else $error("pop from an empty free list");

endmodule
`default_nettype wire

// ===== sv/slpr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slpr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/slpr_age_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot age compare
// Modular frame difference against the idle limit, used by the frame scan.
// ----------------------------------------------------------------------------
module slpr_age_cmp #(
   parameter int FRAME_BITS = 32
) (
   input  logic [FRAME_BITS-1:0]       cur_frame,
   input  logic [FRAME_BITS-1:0]       last_frame,
   input  logic [slpr_pkg::FRAME_W-1:0] idle_limit,
   output logic                        aged
);
   import slpr_pkg::*;

   localparam int CMP_W = (FRAME_BITS > FRAME_W) ? FRAME_BITS : FRAME_W;

   logic [FRAME_BITS-1:0] age;

   // wraps modulo 2^FRAME_BITS by width
   assign age  = cur_frame - last_frame;
   assign aged = CMP_W'(age) >= CMP_W'(idle_limit);

endmodule
`default_nettype wire
